### rtl/sat_rectangle_triangle_collision_top_macros.svh
// assertion helpers for the collision block
`ifndef SAT_RECTANGLE_TRIANGLE_COLLISION_TOP_MACROS_SVH
`define SAT_RECTANGLE_TRIANGLE_COLLISION_TOP_MACROS_SVH
// implication checked on every edge outside reset
`define SRTC_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// implication whose consequent is checked on the next edge
`define SRTC_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

### rtl/srtc_pkg.sv
// ---------------------------------------------------------------------------
// srtc_pkg
// types and constants shared by the collision controller and datapath
// ---------------------------------------------------------------------------
package srtc_pkg;

  localparam int CoordW = 24;
  localparam int NormW  = 16;
  localparam int DepthW = 25;
  localparam logic [DepthW-1:0] DepthMax = '1;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
  } in_item_t;

  typedef struct packed {
    logic                    hit;
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic [DepthW-1:0]       depth;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_EDGE, ST_SCALE, ST_SQ, ST_ROOT, ST_SIGN,
    ST_PROJ, ST_PROJW, ST_JUDGE, ST_OUT
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic store;     // write vertex
    logic edge_ld;   // latch edge of current axis
    logic scale;     // one halving step
    logic sq;        // form squared length
    logic root_init; // start normal search
    logic root_step; // half of one bisection step
    logic sign;      // apply signs to normal
    logic proj_init; // start of projection; unused by the datapath
    logic proj_mul;  // multiply one vertex
    logic proj_acc;  // fold one projection
    logic judge;     // compare overlap
    logic clr_best;  // start of a new set
    logic finish;    // build result
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic scaled;    // both magnitudes below 2^16
    logic root_done; // search intervals closed
    logic miss;      // overlap <= 0 seen
  } stat_t;

endpackage

### rtl/srtc_ctrl.sv
// ---------------------------------------------------------------------------
// srtc_ctrl
// sequencer: vertex loading, per-axis normal, projection and compare
// ---------------------------------------------------------------------------
`include "sat_rectangle_triangle_collision_top_macros.svh"
module srtc_ctrl #(
  parameter int NV   = 7,
  parameter int CNTW = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  srtc_pkg::stat_t   stat,
  output srtc_pkg::cmd_t    cmd,
  output logic [CNTW-1:0]   cnt_r,
  output logic [CNTW-1:0]   axis_r,
  output logic [CNTW-1:0]   pv_r
);

  srtc_pkg::state_t state_r, state_nxt;
  logic [CNTW-1:0] cnt_nxt, axis_nxt, pv_nxt;
  logic            ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srtc_pkg::ST_LOAD;
      cnt_r   <= '0;
      axis_r  <= '0;
      pv_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    pv_nxt    = pv_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = ov_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      srtc_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (cnt_r == CNTW'(NV-1)) begin
            cnt_nxt      = '0;
            axis_nxt     = '0;
            cmd.clr_best = 1'b1;
            in_stall     = 1'b0;
            state_nxt    = srtc_pkg::ST_EDGE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      srtc_pkg::ST_EDGE: begin
        cmd.edge_ld = 1'b1;
        state_nxt   = srtc_pkg::ST_SCALE;
      end
      srtc_pkg::ST_SCALE: begin
        if (stat.scaled) state_nxt = srtc_pkg::ST_SQ;
        else cmd.scale = 1'b1;
      end
      srtc_pkg::ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = srtc_pkg::ST_ROOT;
      end
      srtc_pkg::ST_ROOT: begin
        // search was set up with the squared length; each step squares t, then compares
        if (!stat.root_done) cmd.root_step = 1'b1;
        else state_nxt = srtc_pkg::ST_SIGN;
      end
      srtc_pkg::ST_SIGN: begin
        cmd.sign      = 1'b1;
        cmd.proj_init = 1'b1;
        pv_nxt        = '0;
        state_nxt     = srtc_pkg::ST_PROJ;
      end
      srtc_pkg::ST_PROJ: begin
        cmd.proj_mul = 1'b1;
        state_nxt    = srtc_pkg::ST_PROJW;
      end
      srtc_pkg::ST_PROJW: begin
        cmd.proj_acc = 1'b1;
        if (pv_r == CNTW'(NV-1)) begin
          state_nxt = srtc_pkg::ST_JUDGE;
        end else begin
          pv_nxt    = pv_r + 1'b1;
          state_nxt = srtc_pkg::ST_PROJ;
        end
      end
      srtc_pkg::ST_JUDGE: begin
        cmd.judge = 1'b1;
        if (axis_r == CNTW'(NV-1)) begin
          state_nxt = srtc_pkg::ST_OUT;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = srtc_pkg::ST_EDGE;
        end
      end
      srtc_pkg::ST_OUT: begin
        if (!ov_r || !out_stall) begin
          cmd.finish = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = srtc_pkg::ST_LOAD;
        end
      end
      default: state_nxt = srtc_pkg::ST_LOAD;
    endcase
    // root init is issued on entry to the search
    if (state_r == srtc_pkg::ST_SQ) cmd.root_init = 1'b1;
  end

  `SRTC_ASSERT_IMP(a_stall_busy, clk, rst_n, state_r != srtc_pkg::ST_LOAD, in_stall)
  `SRTC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `SRTC_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r < CNTW'(NV))
  `SRTC_ASSERT_NXT(a_fin_out, clk, rst_n, cmd.finish, out_valid)

endmodule

### rtl/srtc_dp.sv
// ---------------------------------------------------------------------------
// srtc_dp
// vertex store, edge normal search, projection and overlap datapath
// ---------------------------------------------------------------------------
module srtc_dp #(
  parameter int NR   = 4,
  parameter int NT   = 3,
  parameter int NV   = 7,
  parameter int CNTW = 3
) (
  input  logic                clk,
  input  srtc_pkg::in_item_t  in_data,
  input  srtc_pkg::cmd_t      cmd,
  input  logic [CNTW-1:0]     cnt,
  input  logic [CNTW-1:0]     axis,
  input  logic [CNTW-1:0]     pv,
  output srtc_pkg::stat_t     stat,
  output srtc_pkg::out_item_t out_data
);

  localparam int PW = 42; // projection width: 24 x 16 signed plus margin
  localparam int OW = 44;

  logic signed [srtc_pkg::CoordW-1:0] vx_mem [NV];
  logic signed [srtc_pkg::CoordW-1:0] vy_mem [NV];

  logic signed [24:0] ex_r, ey_r;
  logic [24:0]        mx_r, my_r;
  logic [32:0]        s_r;
  logic [14:0]        lox_r, hix_r, loy_r, hiy_r;
  logic [62:0]        rhsx_r, rhsy_r;
  logic [31:0]        ttx_r, tty_r;
  logic               rphase_r;
  logic signed [srtc_pkg::NormW-1:0] nx_r, ny_r;
  logic signed [PW-1:0] px_r, py_r;
  logic signed [PW-1:0] amin_r, amax_r, bmin_r, bmax_r;
  logic signed [OW-1:0] best_ov_r;
  logic                 found_r, miss_r;
  logic signed [srtc_pkg::NormW-1:0] bnx_r, bny_r;
  srtc_pkg::out_item_t  out_r;

  logic [CNTW-1:0] ia, ib;
  logic            in_rect;

  always_comb begin
    in_rect = axis < CNTW'(NR);
    ia      = axis;
    if (in_rect) ib = (axis == CNTW'(NR-1)) ? '0 : axis + 1'b1;
    else ib = (axis == CNTW'(NV-1)) ? CNTW'(NR) : axis + 1'b1;
  end

  // bisection step: t = 2*mid-1, test t*t*s <= rhs
  function automatic logic [14:0] bis_mid(input logic [14:0] lo, input logic [14:0] hi);
    logic [15:0] sum;
    sum = {1'b0, lo} + {1'b0, hi} + 16'd1;
    return sum[15:1];
  endfunction

  // each bisection step first squares t, then scales and compares
  logic [14:0] midx, midy;
  logic [15:0] tx, ty;
  logic [31:0] ttx, tty;
  logic [64:0] lhsx, lhsy;
  always_comb begin
    midx = bis_mid(lox_r, hix_r);
    midy = bis_mid(loy_r, hiy_r);
    tx   = {midx, 1'b0} - 16'd1;
    ty   = {midy, 1'b0} - 16'd1;
    ttx  = tx * tx;
    tty  = ty * ty;
    lhsx = ttx_r * s_r;
    lhsy = tty_r * s_r;
  end

  logic signed [PW-1:0] pcur;
  logic signed [OW-1:0] ov, ovmin, ovmax;
  always_comb begin
    pcur  = px_r + py_r;
    ovmin = (amax_r < bmax_r) ? OW'(amax_r) : OW'(bmax_r);
    ovmax = (amin_r > bmin_r) ? OW'(amin_r) : OW'(bmin_r);
    ov    = ovmin - ovmax;
  end

  logic [OW-1:0] dsum;
  always_comb dsum = best_ov_r + OW'(8192);

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      vx_mem[cnt] <= in_data.vertex_x;
      vy_mem[cnt] <= in_data.vertex_y;
    end
    if (cmd.edge_ld) begin
      ex_r <= 25'(vx_mem[ia]) - 25'(vx_mem[ib]);
      ey_r <= 25'(vy_mem[ia]) - 25'(vy_mem[ib]);
      mx_r <= (vx_mem[ia] >= vx_mem[ib]) ? 25'(25'(vx_mem[ia]) - 25'(vx_mem[ib]))
                                         : 25'(25'(vx_mem[ib]) - 25'(vx_mem[ia]));
      my_r <= (vy_mem[ia] >= vy_mem[ib]) ? 25'(25'(vy_mem[ia]) - 25'(vy_mem[ib]))
                                         : 25'(25'(vy_mem[ib]) - 25'(vy_mem[ia]));
    end
    if (cmd.scale) begin
      mx_r <= mx_r >> 1;
      my_r <= my_r >> 1;
    end
    if (cmd.sq) begin
      s_r <= 33'(mx_r[15:0] * mx_r[15:0]) + 33'(my_r[15:0] * my_r[15:0]);
    end
    if (cmd.root_init) begin
      lox_r    <= '0;
      loy_r    <= '0;
      hix_r    <= 15'd16384;
      hiy_r    <= 15'd16384;
      rphase_r <= 1'b0;
      rhsx_r   <= {15'(0), 32'(my_r[15:0] * my_r[15:0]), 16'(0)} << 14;
      rhsy_r   <= {15'(0), 32'(mx_r[15:0] * mx_r[15:0]), 16'(0)} << 14;
    end
    if (cmd.root_step) begin
      if (!rphase_r) begin
        ttx_r    <= ttx;
        tty_r    <= tty;
        rphase_r <= 1'b1;
      end else begin
        rphase_r <= 1'b0;
        if (lox_r < hix_r) begin
          if (lhsx <= 65'(rhsx_r)) lox_r <= midx;
          else hix_r <= midx - 1'b1;
        end
        if (loy_r < hiy_r) begin
          if (lhsy <= 65'(rhsy_r)) loy_r <= midy;
          else hiy_r <= midy - 1'b1;
        end
      end
    end
    if (cmd.sign) begin
      nx_r <= (s_r == '0) ? '0 : (ey_r > 0) ? -16'(lox_r) : 16'(lox_r);
      ny_r <= (s_r == '0) ? '0 : (ex_r < 0) ? -16'(loy_r) : 16'(loy_r);
    end
    if (cmd.proj_mul) begin
      px_r <= PW'(vx_mem[pv] * nx_r);
      py_r <= PW'(vy_mem[pv] * ny_r);
    end
    if (cmd.proj_acc) begin
      if (pv < CNTW'(NR)) begin
        if (pv == '0 || pcur < amin_r) amin_r <= pcur;
        if (pv == '0 || pcur > amax_r) amax_r <= pcur;
      end else begin
        if (pv == CNTW'(NR) || pcur < bmin_r) bmin_r <= pcur;
        if (pv == CNTW'(NR) || pcur > bmax_r) bmax_r <= pcur;
      end
    end
    if (cmd.clr_best) begin
      found_r   <= 1'b0;
      miss_r    <= 1'b0;
      best_ov_r <= '1;
      bnx_r     <= '0;
      bny_r     <= '0;
    end
    if (cmd.judge) begin
      if (ov <= 0) miss_r <= 1'b1;
      else if (!found_r || ov < best_ov_r) begin
        found_r   <= 1'b1;
        best_ov_r <= ov;
        bnx_r     <= nx_r;
        bny_r     <= ny_r;
      end
    end
    if (cmd.finish) begin
      if (miss_r) out_r <= '0;
      else begin
        out_r.hit      <= 1'b1;
        out_r.normal_x <= bnx_r;
        out_r.normal_y <= bny_r;
        out_r.depth    <= (dsum[OW-1:14] > (OW-14)'(srtc_pkg::DepthMax))
                          ? srtc_pkg::DepthMax : dsum[14+srtc_pkg::DepthW-1:14];
      end
    end
  end

  assign stat.scaled    = (mx_r < 25'd65536) && (my_r < 25'd65536);
  assign stat.root_done = !(lox_r < hix_r) && !(loy_r < hiy_r);
  assign stat.miss      = miss_r;
  assign out_data       = out_r;

endmodule

### rtl/sat_rectangle_triangle_collision_top.sv
// ---------------------------------------------------------------------------
// sat_rectangle_triangle_collision_top
// separating-axis overlap test of a quadrilateral and a triangle
// ---------------------------------------------------------------------------
//  channel | ports                           | moves
//  in      | in_valid in_stall in_data       | one vertex per transfer
//  out     | out_valid out_stall out_data    | one result per vertex set
//
// each vertex but the last is only stored; the last also starts the test
// per axis: edge, halvings until both magnitudes are under 2^16, bisection
// for the normal with steps that square t and then compare, and a multiply
// then a fold per vertex of projection on one multiplier pair; seven axes
// synchronous active-low reset clears the sequencer; out_stall holds the
// result register, and the next set loads while a result waits
module sat_rectangle_triangle_collision_top #(
  parameter int RECT_VERTICES = 4,
  parameter int TRI_VERTICES  = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  srtc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srtc_pkg::out_item_t out_data
);

  localparam int NV   = RECT_VERTICES + TRI_VERTICES;
  localparam int CNTW = $clog2(NV + 1);

  srtc_pkg::cmd_t  cmd;
  srtc_pkg::stat_t stat;
  logic [CNTW-1:0] cnt, axis, pv;

  // sequencer
  srtc_ctrl #(.NV(NV), .CNTW(CNTW)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .cmd, .cnt_r(cnt), .axis_r(axis), .pv_r(pv)
  );

  // arithmetic and vertex storage
  srtc_dp #(.NR(RECT_VERTICES), .NT(TRI_VERTICES), .NV(NV), .CNTW(CNTW)) u_dp (
    .clk, .in_data, .cmd, .cnt, .axis, .pv, .stat, .out_data
  );

endmodule
